// ----- rtl/core/nbg_pkg.sv -----
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared types, widths, register indexes and helpers for the n-body
// gravity step unit.
// ----------------------------------------------------------------------------
package nbg_pkg;

	// defaults for the top-level parameters
	localparam int NUM_BODIES_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;

	// port widths
	localparam int POS_W      = 32;
	localparam int IDX_PORT_W = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRAV   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH   = 3'd4;

	// register reset values (radius and limit in whole units)
	localparam logic [15:0] GRAV_RST   = 16'd6554;
	localparam logic [15:0] MASS_RST   = 16'd100;
	localparam logic [15:0] PUSH_RST   = 16'd6554;
	localparam int          RADIUS_RST = 5;
	localparam int          LIMIT_RST  = 2;

	// datapath widths
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int AX_W   = 33;
	localparam int ROOT_W = 33;
	localparam int D2_W   = 66;
	localparam int D3_W   = 99;
	localparam int QUO_W  = 31;
	localparam int ROW_W  = 4 * POS_W;

	// request to the shared multiplier
	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	// signed 32-bit add with saturation
	function automatic logic signed [POS_W-1:0] sat_add(
		input logic signed [POS_W-1:0] a,
		input logic signed [POS_W-1:0] b
	);
		logic signed [POS_W:0] s;
		s = {a[POS_W-1], a} + {b[POS_W-1], b};
		if (s[POS_W] != s[POS_W-1]) begin
			sat_add = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			sat_add = s[POS_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/core/nbg_mul.sv -----
// ----------------------------------------------------------------------------
// nbg_mul
// Shared unsigned multiplier, one product per cycle, result registered.
// ----------------------------------------------------------------------------
module nbg_mul
	import nbg_pkg::*;
(
	input  logic              clk,
	input  mul_req_t          req,
	output logic [PROD_W-1:0] prod_q
);

	// product is registered, ready in the cycle after the request
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
	end

endmodule

// ----- rtl/core/nbody_gravity_step_unit.sv -----
// ----------------------------------------------------------------------------
// nbody_gravity_step_unit
// Direct 2D n-body gravity with Euler update, Q16.16 fixed point, built
// around one shared multiplier plus bit-serial square root and divider.
// ----------------------------------------------------------------------------
//  channel  signals                                   word
//  in       in_valid / in_stall                       func, body_index, load_*
//  out      out_valid / out_stall                     out_index, new_pos_x/y, last_body
//  cfg      cfg_we, cfg_index, cfg_data               one register write
//
//  A load writes the body store directly and leaves the input channel free.
//  A tick runs every body against each other body; a pair in contact adds
//  the fixed push, a gravity pair runs the setup states, 33 square-root
//  steps, the cube (DD, D3A, D3B, D3C), then per axis up to 31 divide steps.
//  The body store is one 128-bit-row memory with a registered read port;
//  per-row valid bits cleared by reset make every body read as zero until written.
//  in_stall is high for the whole tick; a stalled result holds the
//  sequencer at the emit step.
// ----------------------------------------------------------------------------
module nbody_gravity_step_unit
	import nbg_pkg::*;
#(
	parameter int NUM_BODIES = NUM_BODIES_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [IDX_PORT_W-1:0]        body_index,
	input  logic signed [POS_W-1:0]      load_pos_x,
	input  logic signed [POS_W-1:0]      load_pos_y,
	input  logic signed [POS_W-1:0]      load_vel_x,
	input  logic signed [POS_W-1:0]      load_vel_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [IDX_PORT_W-1:0]        out_index,
	output logic signed [POS_W-1:0]      new_pos_x,
	output logic signed [POS_W-1:0]      new_pos_y,
	output logic                         last_body,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int IDX_W = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int SH    = 3 * FRAC_BITS - 16;
	localparam int NUM_W = 65 + SH;
	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > D3_W) ? HI_W : D3_W;
	localparam int R_W   = (FRAC_BITS + 3 > CFG_DATA_W) ? FRAC_BITS + 3 : CFG_DATA_W;
	localparam int L_W   = (FRAC_BITS + 2 > CFG_DATA_W) ? FRAC_BITS + 2 : CFG_DATA_W;
	localparam int P_LS  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int P_RS  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int P_W   = 16 + P_LS;

	// sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_GM   = 5'd1;
	localparam logic [4:0] ST_C2   = 5'd2;
	localparam logic [4:0] ST_RDI  = 5'd3;
	localparam logic [4:0] ST_LDI  = 5'd4;
	localparam logic [4:0] ST_RDJ  = 5'd5;
	localparam logic [4:0] ST_DIFF = 5'd6;
	localparam logic [4:0] ST_SQX  = 5'd7;
	localparam logic [4:0] ST_SQY  = 5'd8;
	localparam logic [4:0] ST_D2   = 5'd9;
	localparam logic [4:0] ST_CMP  = 5'd10;
	localparam logic [4:0] ST_SQRT = 5'd11;
	localparam logic [4:0] ST_DD   = 5'd12;
	localparam logic [4:0] ST_D3A  = 5'd13;
	localparam logic [4:0] ST_D3B  = 5'd14;
	localparam logic [4:0] ST_D3C  = 5'd15;
	localparam logic [4:0] ST_AXIS = 5'd16;
	localparam logic [4:0] ST_NUM  = 5'd17;
	localparam logic [4:0] ST_DIV  = 5'd18;
	localparam logic [4:0] ST_ACC  = 5'd19;
	localparam logic [4:0] ST_UPD  = 5'd20;
	localparam logic [4:0] ST_EMIT = 5'd21;

	// configuration registers
	logic [15:0]    grav_q, mass_q, push_q;
	logic [R_W-1:0] radius_q;
	logic [L_W-1:0] limit_q;

	// control state
	logic [4:0]            state_q;
	logic [IDX_W-1:0]      i_q;
	logic [CNT_W-1:0]      j_q;
	logic                  axis_q;
	logic [5:0]            scnt_q;
	logic [4:0]            dcnt_q;
	logic                  out_valid_q;
	logic [NUM_BODIES-1:0] row_vld_q;

	// body store
	logic [ROW_W-1:0] mem [NUM_BODIES];
	logic [ROW_W-1:0] rd_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] wr_addr;
	logic [ROW_W-1:0] wr_data;

	// datapath registers
	logic signed [POS_W-1:0] xi_q, yi_q, vxi_q, vyi_q;
	logic signed [POS_W-1:0] acc_x_q, acc_y_q;
	logic [AX_W-1:0]         ax_q, ay_q;
	logic                    nx_q, ny_q, px_q, py_q;
	logic [D2_W-1:0]         d2_q, c2_q;
	logic [ROOT_W-1:0]       root_q;
	logic [ROOT_W:0]         srem_q;
	logic [ROOT_W-1:0]       hh_q;
	logic [D3_W-1:0]         d3_q;
	logic [31:0]             gm_q;
	logic [D3_W-1:0]         rem_q;
	logic [QUO_W-1:0]        numlo_q;
	logic [QUO_W-1:0]        quo_q;
	logic signed [POS_W-1:0] out_x_q, out_y_q;
	logic [IDX_PORT_W-1:0]   out_idx_q;
	logic                    out_last_q;

	// shared multiplier
	mul_req_t          mreq;
	logic [PROD_W-1:0] prod_q;

	nbg_mul u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_q (prod_q)
	);

	// combinational helpers
	logic                    in_acc, tick_go, load_go, emit_go;
	logic [R_W:0]            contact_c;
	logic [P_W-1:0]          push_w;
	logic signed [POS_W-1:0] push_s;
	logic signed [POS_W-1:0] xj_w, yj_w, vx_rd, vy_rd;
	logic signed [AX_W-1:0]  dx_w, dy_w;
	logic                    contact_w;
	logic [CNT_W-1:0]        jp1_w, jn_w, j_first_w;
	logic                    j_done_w;
	logic [ROOT_W+2:0]       s_cur_w, s_trial_w;
	logic [NUM_W-1:0]        num_w;
	logic [CMP_W-1:0]        hi_ext_w, d3_ext_w;
	logic [D3_W:0]           d_cur_w;
	logic [AX_W-1:0]         a_sel_w;
	logic                    neg_sel_w;
	logic signed [POS_W-1:0] qv_w, term_w;
	logic signed [POS_W-1:0] lim_w, vx_sat_w, vy_sat_w, vx_cl_w, vy_cl_w;
	logic signed [POS_W-1:0] nx_pos_w, ny_pos_w;
	logic                    last_w;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign tick_go   = in_acc && func;
	assign load_go   = in_acc && !func && (32'(body_index) < 32'(NUM_BODIES));
	assign emit_go   = (state_q == ST_EMIT) && !(out_valid_q && out_stall);
	assign last_w    = (32'(i_q) == 32'(NUM_BODIES - 1));

	assign contact_c = {radius_q, 1'b0};
	assign push_w    = (P_W'(push_q) << P_LS) >> P_RS;
	assign push_s    = $signed(POS_W'(push_w));

	// row fields, zero for a never-written row
	assign xj_w  = rd_vld_q ? $signed(rd_q[4*POS_W-1:3*POS_W]) : '0;
	assign yj_w  = rd_vld_q ? $signed(rd_q[3*POS_W-1:2*POS_W]) : '0;
	assign vx_rd = rd_vld_q ? $signed(rd_q[2*POS_W-1:POS_W]) : '0;
	assign vy_rd = rd_vld_q ? $signed(rd_q[POS_W-1:0]) : '0;

	assign dx_w = {xj_w[POS_W-1], xj_w} - {xi_q[POS_W-1], xi_q};
	assign dy_w = {yj_w[POS_W-1], yj_w} - {yi_q[POS_W-1], yi_q};

	assign contact_w = (d2_q <= c2_q);

	// next partner index, skipping the body itself
	assign jp1_w     = j_q + CNT_W'(1);
	assign jn_w      = (jp1_w == {1'b0, i_q}) ? j_q + CNT_W'(2) : jp1_w;
	assign j_done_w  = (jn_w >= CNT_W'(NUM_BODIES));
	assign j_first_w = (i_q == '0) ? CNT_W'(1) : '0;

	// square-root step: two radicand bits per cycle
	assign s_cur_w   = {srem_q, d2_q[D2_W-1:D2_W-2]};
	assign s_trial_w = {1'b0, root_q, 2'b01};

	// numerator and divide step
	assign num_w    = NUM_W'(prod_q[64:0]) << SH;
	assign hi_ext_w = CMP_W'(num_w[NUM_W-1:QUO_W]);
	assign d3_ext_w = CMP_W'(d3_q);
	assign d_cur_w  = {rem_q, numlo_q[QUO_W-1]};

	assign a_sel_w   = axis_q ? ay_q : ax_q;
	assign neg_sel_w = axis_q ? ny_q : nx_q;
	assign qv_w      = $signed({1'b0, quo_q});
	assign term_w    = neg_sel_w ? -qv_w : qv_w;

	// velocity update and clamp
	assign lim_w    = $signed(POS_W'(limit_q));
	assign vx_sat_w = sat_add(vxi_q, acc_x_q);
	assign vy_sat_w = sat_add(vyi_q, acc_y_q);

	always_comb begin
		vx_cl_w = vx_sat_w;
		if (vx_sat_w > lim_w) begin
			vx_cl_w = lim_w;
		end else if (vx_sat_w < -lim_w) begin
			vx_cl_w = -lim_w;
		end
		vy_cl_w = vy_sat_w;
		if (vy_sat_w > lim_w) begin
			vy_cl_w = lim_w;
		end else if (vy_sat_w < -lim_w) begin
			vy_cl_w = -lim_w;
		end
	end

	assign nx_pos_w = sat_add(xi_q, vxi_q);
	assign ny_pos_w = sat_add(yi_q, vyi_q);

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_IDLE: mreq = '{a: MUL_W'(grav_q), b: MUL_W'(mass_q)};
			ST_GM:   mreq = '{a: MUL_W'(contact_c), b: MUL_W'(contact_c)};
			ST_SQX:  mreq = '{a: MUL_W'(ax_q), b: MUL_W'(ax_q)};
			ST_SQY:  mreq = '{a: MUL_W'(ay_q), b: MUL_W'(ay_q)};
			ST_DD:   mreq = '{a: MUL_W'(root_q), b: MUL_W'(root_q)};
			ST_D3A:  mreq = '{a: MUL_W'(prod_q[ROOT_W-1:0]), b: MUL_W'(root_q)};
			ST_D3B:  mreq = '{a: MUL_W'(hh_q), b: MUL_W'(root_q)};
			ST_AXIS: mreq = '{a: MUL_W'(gm_q), b: MUL_W'(a_sel_w)};
			default: mreq = '0;
		endcase
	end

	// store port control
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = i_q;
		wr_data = {nx_pos_w, ny_pos_w, vxi_q, vyi_q};
		rd_addr = (state_q == ST_RDI) ? i_q : j_q[IDX_W-1:0];
		if (load_go) begin
			mem_we  = 1'b1;
			wr_addr = body_index[IDX_W-1:0];
			wr_data = {load_pos_x, load_pos_y, load_vel_x, load_vel_y};
		end else if (emit_go) begin
			mem_we = 1'b1;
		end
	end

	// body store memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// row valid bits and read flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= GRAV_RST;
			mass_q   <= MASS_RST;
			radius_q <= R_W'(RADIUS_RST) << FRAC_BITS;
			limit_q  <= L_W'(LIMIT_RST) << FRAC_BITS;
			push_q   <= PUSH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAV:   grav_q   <= cfg_data[15:0];
				REG_MASS:   mass_q   <= cfg_data[15:0];
				REG_RADIUS: radius_q <= R_W'(cfg_data);
				REG_LIMIT:  limit_q  <= L_W'(cfg_data);
				REG_PUSH:   push_q   <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			axis_q      <= 1'b0;
			scnt_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result word: set on emit, cleared once taken
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						state_q <= ST_GM;
					end
				end
				ST_GM: state_q <= ST_C2;
				ST_C2: begin
					i_q     <= '0;
					state_q <= ST_RDI;
				end
				ST_RDI: state_q <= ST_LDI;
				ST_LDI: begin
					j_q     <= j_first_w;
					state_q <= ST_RDJ;
				end
				ST_RDJ:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_D2;
				ST_D2:   state_q <= ST_CMP;
				ST_CMP: begin
					if (contact_w) begin
						j_q     <= jn_w;
						state_q <= j_done_w ? ST_UPD : ST_RDJ;
					end else begin
						scnt_q  <= 6'd32;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					scnt_q <= scnt_q - 6'd1;
					if (scnt_q == '0) begin
						state_q <= ST_DD;
					end
				end
				ST_DD:  state_q <= ST_D3A;
				ST_D3A: state_q <= ST_D3B;
				ST_D3B: state_q <= ST_D3C;
				ST_D3C: begin
					axis_q  <= 1'b0;
					state_q <= ST_AXIS;
				end
				ST_AXIS: state_q <= ST_NUM;
				ST_NUM: begin
					if (a_sel_w == '0 || hi_ext_w >= d3_ext_w) begin
						state_q <= ST_ACC;
					end else begin
						dcnt_q  <= 5'd30;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_AXIS;
					end else begin
						j_q     <= jn_w;
						state_q <= j_done_w ? ST_UPD : ST_RDJ;
					end
				end
				ST_UPD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						if (last_w) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							state_q <= ST_RDI;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_GM: gm_q <= prod_q[31:0];
			ST_C2: c2_q <= prod_q[D2_W-1:0];
			ST_LDI: begin
				xi_q    <= xj_w;
				yi_q    <= yj_w;
				vxi_q   <= vx_rd;
				vyi_q   <= vy_rd;
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
			ST_DIFF: begin
				ax_q <= dx_w[AX_W-1] ? -dx_w : dx_w;
				ay_q <= dy_w[AX_W-1] ? -dy_w : dy_w;
				nx_q <= dx_w[AX_W-1];
				ny_q <= dy_w[AX_W-1];
				px_q <= !dx_w[AX_W-1] && (dx_w != '0);
				py_q <= !dy_w[AX_W-1] && (dy_w != '0);
			end
			ST_SQY: d2_q <= prod_q[D2_W-1:0];
			ST_D2:  d2_q <= d2_q + prod_q[D2_W-1:0];
			ST_CMP: begin
				if (contact_w) begin
					acc_x_q <= sat_add(acc_x_q, px_q ? -push_s : push_s);
					acc_y_q <= sat_add(acc_y_q, py_q ? -push_s : push_s);
				end
				root_q <= '0;
				srem_q <= '0;
			end
			ST_SQRT: begin
				if (s_cur_w >= s_trial_w) begin
					srem_q <= (ROOT_W+1)'(s_cur_w - s_trial_w);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= s_cur_w[ROOT_W:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				d2_q <= d2_q << 2;
			end
			ST_D3A: hh_q <= prod_q[D2_W-1:ROOT_W];
			ST_D3B: d3_q <= D3_W'(prod_q[D2_W-1:0]);
			ST_D3C: d3_q <= d3_q + {prod_q[D2_W-1:0], {ROOT_W{1'b0}}};
			ST_NUM: begin
				if (a_sel_w == '0) begin
					quo_q <= '0;
				end else if (hi_ext_w >= d3_ext_w) begin
					quo_q <= '1;
				end else begin
					quo_q <= '0;
				end
				rem_q   <= D3_W'(hi_ext_w);
				numlo_q <= num_w[QUO_W-1:0];
			end
			ST_DIV: begin
				if (d_cur_w >= {1'b0, d3_q}) begin
					rem_q <= D3_W'(d_cur_w - {1'b0, d3_q});
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= d_cur_w[D3_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				numlo_q <= numlo_q << 1;
			end
			ST_ACC: begin
				if (axis_q) begin
					acc_y_q <= sat_add(acc_y_q, term_w);
				end else begin
					acc_x_q <= sat_add(acc_x_q, term_w);
				end
			end
			ST_UPD: begin
				vxi_q <= vx_cl_w;
				vyi_q <= vy_cl_w;
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_x_q    <= nx_pos_w;
					out_y_q    <= ny_pos_w;
					out_idx_q  <= IDX_PORT_W'(i_q);
					out_last_q <= last_w;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_index = out_idx_q;
	assign new_pos_x = out_x_q;
	assign new_pos_y = out_y_q;
	assign last_body = out_last_q;

endmodule

// ----- rtl/core/nbg_checker.sv -----
// ----------------------------------------------------------------------------
// nbg_checker
// Port-level checks on the n-body step unit, bound to the top level.
// ----------------------------------------------------------------------------
module nbg_checker #(
	parameter int NUM_BODIES = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        func,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  out_index,
	input logic [31:0] new_pos_x,
	input logic [31:0] new_pos_y,
	input logic        last_body
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_index) && $stable(new_pos_x)
			&& $stable(new_pos_y) && $stable(last_body))
		else $error("result word changed while stalled");

	// a tick blocks further input while it runs
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func |=> in_stall)
		else $error("input taken during a tick");

	// a load leaves the input channel free for the next command
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !func |=> !in_stall)
		else $error("load did not complete in one cycle");

	// last flag marks the final body
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_body |-> out_index == 6'(NUM_BODIES - 1))
		else $error("last flag on wrong body");

endmodule

bind nbody_gravity_step_unit nbg_checker #(.NUM_BODIES(NUM_BODIES)) u_nbg_checker (.*);

// ----- tb/nbody_gravity_step_unit_tb.sv -----
// ----------------------------------------------------------------------------
// nbody_gravity_step_unit_tb
// Self-checking bench for the n-body gravity step unit. Body loads and
// ticks go in through the valid/stall input channel. A scoreboard keeps
// its own copy of the body store and registers, predicts the new position
// of every body on each tick, and compares each output word in order.
// The run goes through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module nbody_gravity_step_unit_tb;
	import nbg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBODY = 64;
	localparam bit FN_LOAD = 1'b0;
	localparam bit FN_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] POS_MIN = 32'sh80000000;

	typedef struct {
		bit                 func;
		logic [5:0]         idx;
		logic signed [31:0] px, py, vx, vy;
	} body_cmd_t;

	typedef struct {
		logic [5:0]         idx;
		logic signed [31:0] x, y;
		logic               last;
	} body_word_t;

	// Scoreboard: owns the predicted body store and the queue of new positions
	class orbit_board;
		longint         pos_x[NBODY], pos_y[NBODY], vel_x[NBODY], vel_y[NBODY];
		longint unsigned g_const, mass, radius, vlimit, push;
		body_word_t     pending_pos[$];
		int             mismatches;

		function new();
			for (int k = 0; k < NBODY; k++) begin
				pos_x[k] = 0; pos_y[k] = 0; vel_x[k] = 0; vel_y[k] = 0;
			end
			g_const = 6554; mass = 100; radius = 5 << 16; vlimit = 2 << 16; push = 6554;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_pos.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRAV:   g_const = 64'(data[15:0]);
				REG_MASS:   mass    = 64'(data[15:0]);
				REG_RADIUS: radius  = 64'(data);
				REG_LIMIT:  vlimit  = 64'(data);
				REG_PUSH:   push    = 64'(data[15:0]);
				default: ;
			endcase
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function logic [127:0] root_floor(logic [127:0] v);
			logic [127:0] res, cand;
			res = 0;
			for (int b = 33; b >= 0; b--) begin
				cand = res | (128'd1 << b);
				if (cand * cand <= v) res = cand;
			end
			return res;
		endfunction

		// one axis of the gravity pull: G*m*|d| * 2^32 / sep^3, saturated
		function longint pull_axis(longint unsigned mag, bit neg, logic [127:0] sep);
			logic [127:0] num, den, q;
			longint v;
			num = (128'(g_const * mass) * 128'(mag)) << 32;
			den = sep * sep * sep;
			q = num / den;
			v = (q > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(q);
			return neg ? -v : v;
		endfunction

		function void note_cmd(body_cmd_t c);
			longint acc_x, acc_y, dx, dy, tx, ty, nvx, nvy, lim;
			longint unsigned adx, ady;
			logic [127:0] d2, c2;
			body_word_t w;
			if (c.func == FN_LOAD) begin
				pos_x[c.idx] = c.px; pos_y[c.idx] = c.py;
				vel_x[c.idx] = c.vx; vel_y[c.idx] = c.vy;
				return;
			end
			c2 = 128'(2 * radius) * 128'(2 * radius);
			lim = longint'(vlimit);
			for (int i = 0; i < NBODY; i++) begin
				acc_x = 0; acc_y = 0;
				for (int j = 0; j < NBODY; j++) begin
					if (i != j) begin
						dx = pos_x[j] - pos_x[i];
						dy = pos_y[j] - pos_y[i];
						adx = (dx < 0) ? -dx : dx;
						ady = (dy < 0) ? -dy : dy;
						d2 = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
						if (d2 <= c2) begin
							// overlap: fixed push away, positive on equal coordinates
							tx = (dx > 0) ? -longint'(push) : longint'(push);
							ty = (dy > 0) ? -longint'(push) : longint'(push);
						end else begin
							tx = (adx != 0) ? pull_axis(adx, dx < 0, root_floor(d2)) : 0;
							ty = (ady != 0) ? pull_axis(ady, dy < 0, root_floor(d2)) : 0;
						end
						acc_x = clip32(acc_x + tx);
						acc_y = clip32(acc_y + ty);
					end
				end
				nvx = clip32(vel_x[i] + acc_x);
				nvy = clip32(vel_y[i] + acc_y);
				if (nvx > lim) nvx = lim;
				if (nvx < -lim) nvx = -lim;
				if (nvy > lim) nvy = lim;
				if (nvy < -lim) nvy = -lim;
				vel_x[i] = nvx; vel_y[i] = nvy;
				pos_x[i] = clip32(pos_x[i] + nvx);
				pos_y[i] = clip32(pos_y[i] + nvy);
				w.idx = 6'(i); w.x = 32'(pos_x[i]); w.y = 32'(pos_y[i]);
				w.last = (i == NBODY - 1);
				pending_pos.push_back(w);
			end
		endfunction

		function void check_word(body_word_t got);
			body_word_t exp_w;
			if (pending_pos.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: idx %0d pos (%0d,%0d) last %0b",
						got.idx, got.x, got.y, got.last);
				return;
			end
			exp_w = pending_pos.pop_front();
			if (got.idx !== exp_w.idx || got.x !== exp_w.x || got.y !== exp_w.y ||
					got.last !== exp_w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected idx %0d pos (%0d,%0d) last %0b, got idx %0d pos (%0d,%0d) last %0b",
						exp_w.idx, exp_w.x, exp_w.y, exp_w.last,
						got.idx, got.x, got.y, got.last);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, func;
	logic [IDX_PORT_W-1:0] body_index;
	logic signed [POS_W-1:0] load_pos_x, load_pos_y, load_vel_x, load_vel_y;
	logic out_valid, out_stall, last_body;
	logic [IDX_PORT_W-1:0] out_index;
	logic signed [POS_W-1:0] new_pos_x, new_pos_y;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	orbit_board book;
	int idle_pct, stall_pct, hold_left;

	nbody_gravity_step_unit u_top (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#480_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: random stall, or a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		body_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			w.idx = out_index; w.x = new_pos_x; w.y = new_pos_y; w.last = last_body;
			book.check_word(w);
		end
	end

	task automatic send_cmd(body_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= c.func;
		body_index <= c.idx;
		load_pos_x <= c.px;
		load_pos_y <= c.py;
		load_vel_x <= c.vx;
		load_vel_y <= c.vy;
		do @(posedge clk); while (in_stall);
		book.note_cmd(c);
		@(negedge clk);
	endtask

	task automatic send_load(int idx, logic signed [31:0] px, py, vx, vy);
		body_cmd_t c;
		c.func = FN_LOAD; c.idx = 6'(idx); c.px = px; c.py = py; c.vx = vx; c.vy = vy;
		send_cmd(c);
	endtask

	task automatic send_tick();
		body_cmd_t c;
		c.func = FN_TICK; c.idx = 6'($urandom); c.px = $urandom; c.py = $urandom;
		c.vx = $urandom; c.vy = $urandom;
		send_cmd(c);
	endtask

	// drop valid, wait for all pending words, then let the unit settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(negedge clk);
		repeat (32) @(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		book.write_reg(idx, data);
	endtask

	function automatic logic signed [31:0] near_val(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	initial begin
		body_cmd_t c;
		book = new();
		idle_pct = 0; stall_pct = 0; hold_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; func = FN_LOAD; body_index = '0;
		load_pos_x = '0; load_pos_y = '0; load_vel_x = '0; load_vel_y = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: ignored register, field extremes, overlap and gravity pairs
		write_cfg(REG_UNUSED, 24'hFFFFFF);
		send_load(0, POS_MAX, POS_MIN, POS_MAX, POS_MIN);
		send_load(63, POS_MIN, POS_MAX, POS_MIN, POS_MAX);
		send_load(1, 0, 0, 0, 0);
		send_load(2, 3 << 16, -(3 << 16), 1 << 16, -(1 << 16));
		send_load(3, 100 << 16, 50 << 16, 0, 0);
		send_load(4, 100 << 16, 80 << 16, 0, 0);
		send_load(5, 32'sh7FFFFFF0, -32'sh7FFFFFF0, 32'sh00100000, -32'sh00100000);
		send_tick();
		wait_idle();
		send_tick();
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				1: begin
					write_cfg(REG_GRAV, 24'h00FFFF);
					write_cfg(REG_MASS, 24'h00FFFF);
					write_cfg(REG_RADIUS, 24'hFFFFFF);
					write_cfg(REG_LIMIT, 24'hFFFFFF);
					write_cfg(REG_PUSH, 24'h00FFFF);
				end
				2: begin
					write_cfg(REG_GRAV, '0);
					write_cfg(REG_MASS, '0);
					write_cfg(REG_RADIUS, '0);
					write_cfg(REG_LIMIT, '0);
					write_cfg(REG_PUSH, '0);
				end
				3: begin
					write_cfg(REG_GRAV, CFG_DATA_W'($urandom_range(16'hFFFF)));
					write_cfg(REG_MASS, CFG_DATA_W'($urandom_range(16'hFFFF, 1)));
					write_cfg(REG_RADIUS, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
					write_cfg(REG_LIMIT, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
					write_cfg(REG_PUSH, CFG_DATA_W'($urandom_range(16'hFFFF)));
				end
				default: ;
			endcase
			idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 21 : 0;
			stall_pct = (ph == 2) ? 68 : (ph == 3) ? 21 : 0;

			// receiver holds off through a tick while the next load waits at the stalled input
			if (ph == 2) begin
				hold_left = 20000;
				send_tick();
			end
			for (int n = 0; n < 24; n++) begin
				if ($urandom_range(24) == 0) begin
					send_tick();
				end else begin
					c.func = FN_LOAD;
					c.idx  = 6'($urandom_range(63));
					if ($urandom_range(7) == 0) begin
						c.px = $urandom; c.py = $urandom;
					end else begin
						c.px = near_val(1 << 22); c.py = near_val(1 << 22);
					end
					if ($urandom_range(7) == 0) begin
						c.vx = $urandom; c.vy = $urandom;
					end else begin
						c.vx = near_val(1 << 17); c.vy = near_val(1 << 17);
					end
					send_cmd(c);
				end
			end
			send_tick();
			wait_idle();
		end

		if (book.mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
